>>> rtl/aob_pkg.sv
package aob_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned NumCh = 3;
  localparam int unsigned ProdW = 2 * ChanW;
  localparam int unsigned DenW  = 2 * ChanW;
  localparam int unsigned NumW  = 3 * ChanW;
  localparam int unsigned QuoW  = ChanW;

  localparam logic [ChanW-1:0] ChanMax = '1;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    chan_t [NumCh-1:0] fg_c;
    chan_t             fg_a;
    chan_t [NumCh-1:0] bg_c;
    chan_t             bg_a;
  } pix_pair_t;

  // fg colour times fg alpha, bg weight a2*(255-a1)
  typedef struct packed {
    logic [NumCh-1:0][ProdW-1:0] ca;
    chan_t [NumCh-1:0]           bg_c;
    chan_t                       fg_a;
    logic [ProdW-1:0]            w2;
  } mul_t;

  typedef struct packed {
    logic [NumCh-1:0][NumW-1:0] num;
    logic [DenW-1:0]            den;
  } sum_t;

  typedef struct packed {
    logic [NumCh-1:0][NumW-1:0] rem;
    logic [NumCh-1:0][QuoW-1:0] quo;
    logic [DenW-1:0]            den;
    chan_t                      alpha_est;
  } div_t;

endpackage

>>> rtl/aob_in_if.sv
interface aob_in_if;
  logic                 valid;
  logic                 ready;
  aob_pkg::chan_t       fg_red;
  aob_pkg::chan_t       fg_green;
  aob_pkg::chan_t       fg_blue;
  aob_pkg::chan_t       fg_alpha;
  aob_pkg::chan_t       bg_red;
  aob_pkg::chan_t       bg_green;
  aob_pkg::chan_t       bg_blue;
  aob_pkg::chan_t       bg_alpha;

  modport source (
    output valid, fg_red, fg_green, fg_blue, fg_alpha,
           bg_red, bg_green, bg_blue, bg_alpha,
    input  ready
  );

  modport sink (
    input  valid, fg_red, fg_green, fg_blue, fg_alpha,
           bg_red, bg_green, bg_blue, bg_alpha,
    output ready
  );
endinterface

>>> rtl/aob_out_if.sv
interface aob_out_if;
  logic           valid;
  logic           ready;
  aob_pkg::chan_t out_red;
  aob_pkg::chan_t out_green;
  aob_pkg::chan_t out_blue;
  aob_pkg::chan_t out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

>>> rtl/aob_front.sv
module aob_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  aob_pkg::pix_pair_t pix_i,
  output logic              valid_o,
  input  logic              ready_i,
  output aob_pkg::div_t     data_o
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  aob_pkg::mul_t s1_d, s1_q;
  aob_pkg::sum_t s2_d, s2_q;
  aob_pkg::div_t s3_d, s3_q;

  logic [aob_pkg::NumW-1:0] den_x257;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // products
  always_comb begin
    for (int k = 0; k < aob_pkg::NumCh; k++) begin
      s1_d.ca[k]   = aob_pkg::ProdW'(pix_i.fg_c[k]) * aob_pkg::ProdW'(pix_i.fg_a);
      s1_d.bg_c[k] = pix_i.bg_c[k];
    end
    s1_d.fg_a = pix_i.fg_a;
    s1_d.w2   = aob_pkg::ProdW'(pix_i.bg_a) *
                aob_pkg::ProdW'(aob_pkg::ChanMax - pix_i.fg_a);
  end

  // numerators and denominator
  always_comb begin
    for (int k = 0; k < aob_pkg::NumCh; k++) begin
      s2_d.num[k] = ({s1_q.ca[k], aob_pkg::ChanW'(0)} - aob_pkg::NumW'(s1_q.ca[k]))
                  + aob_pkg::NumW'(s1_q.bg_c[k]) * aob_pkg::NumW'(s1_q.w2);
    end
    s2_d.den = ({s1_q.fg_a, aob_pkg::ChanW'(0)} - aob_pkg::DenW'(s1_q.fg_a)) + s1_q.w2;
  end

  // alpha estimate: den * 257 / 65536, at most one below den / 255
  assign den_x257 = {s2_q.den, aob_pkg::ChanW'(0)} + aob_pkg::NumW'(s2_q.den);

  always_comb begin
    s3_d.rem       = s2_q.num;
    s3_d.quo       = '0;
    s3_d.den       = s2_q.den;
    s3_d.alpha_est = den_x257[aob_pkg::NumW-1 -: aob_pkg::ChanW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q)    s2_q <= s2_d;
    if (rdy3 && v2_q)    s3_q <= s3_d;
  end

  assign valid_o = v3_q;
  assign data_o  = s3_q;

endmodule

>>> rtl/aob_div_step.sv
module aob_div_step #(
  parameter int unsigned BitIdx = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  aob_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output aob_pkg::div_t data_o
);

  logic          valid_q;
  aob_pkg::div_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  // one restoring quotient bit per channel
  always_comb begin
    logic [aob_pkg::NumW-1:0] dsh;
    dsh    = aob_pkg::NumW'(data_i.den) << BitIdx;
    data_d = data_i;
    for (int k = 0; k < aob_pkg::NumCh; k++) begin
      if (data_i.rem[k] >= dsh) begin
        data_d.rem[k]         = data_i.rem[k] - dsh;
        data_d.quo[k][BitIdx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/aob_out_stage.sv
module aob_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  aob_pkg::div_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output aob_pkg::chan_t red_o,
  output aob_pkg::chan_t green_o,
  output aob_pkg::chan_t blue_o,
  output aob_pkg::chan_t alpha_o
);

  logic                         valid_q;
  logic                         den_zero;
  logic [aob_pkg::DenW-1:0]     est_x255;
  logic [aob_pkg::DenW-1:0]     alpha_rem;
  aob_pkg::chan_t [aob_pkg::NumCh-1:0] col_d, col_q;
  aob_pkg::chan_t               alpha_d, alpha_q;

  assign ready_o  = !valid_q || ready_i;
  assign den_zero = (data_i.den == '0);

  // both alphas clear gives a clear black pixel
  always_comb begin
    for (int k = 0; k < aob_pkg::NumCh; k++) begin
      col_d[k] = den_zero ? '0 : data_i.quo[k];
    end
  end

  assign est_x255  = {data_i.alpha_est, aob_pkg::ChanW'(0)}
                   - aob_pkg::DenW'(data_i.alpha_est);
  assign alpha_rem = data_i.den - est_x255;
  assign alpha_d   = (alpha_rem >= aob_pkg::DenW'(aob_pkg::ChanMax))
                   ? data_i.alpha_est + aob_pkg::ChanW'(1) : data_i.alpha_est;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      col_q   <= col_d;
      alpha_q <= alpha_d;
    end
  end

  assign valid_o = valid_q;
  assign red_o   = col_q[0];
  assign green_o = col_q[1];
  assign blue_o  = col_q[2];
  assign alpha_o = alpha_q;

endmodule

>>> rtl/alpha_over_blend.sv
// Alpha "over" compositing for straight (non-premultiplied) RGBA8 pixels: each request
// carries a foreground and a background pixel and yields one blended pixel. The block takes
// one request per clock when not back-pressured and is fully pipelined with no state between
// pixels. There are twelve register stages: three for products, sums and an alpha estimate,
// eight for a restoring divider that settles one quotient bit each for all three colours, and
// an output register that fixes up alpha. Back-pressure stalls only the stages that hold data,
// so bubbles are squeezed out. When both alphas are zero the result is all zero.
module alpha_over_blend (
  input  logic       clk_i,
  input  logic       rst_ni,
  aob_in_if.sink     in_i,
  aob_out_if.source  out_o
);

  localparam int unsigned NumSteps = aob_pkg::QuoW;

  aob_pkg::pix_pair_t pix;
  aob_pkg::div_t      chain_data  [NumSteps+1];
  logic               chain_valid [NumSteps+1];
  logic               chain_ready [NumSteps+1];

  assign pix.fg_c[0] = in_i.fg_red;
  assign pix.fg_c[1] = in_i.fg_green;
  assign pix.fg_c[2] = in_i.fg_blue;
  assign pix.fg_a    = in_i.fg_alpha;
  assign pix.bg_c[0] = in_i.bg_red;
  assign pix.bg_c[1] = in_i.bg_green;
  assign pix.bg_c[2] = in_i.bg_blue;
  assign pix.bg_a    = in_i.bg_alpha;

  aob_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .pix_i   (pix),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .data_o  (chain_data[0])
  );

  for (genvar j = 0; j < NumSteps; j++) begin : g_div
    aob_div_step #(
      .BitIdx (NumSteps - 1 - j)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[j]),
      .ready_o (chain_ready[j]),
      .data_i  (chain_data[j]),
      .valid_o (chain_valid[j+1]),
      .ready_i (chain_ready[j+1]),
      .data_o  (chain_data[j+1])
    );
  end

  aob_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[NumSteps]),
    .ready_o (chain_ready[NumSteps]),
    .data_i  (chain_data[NumSteps]),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .red_o   (out_o.out_red),
    .green_o (out_o.out_green),
    .blue_o  (out_o.out_blue),
    .alpha_o (out_o.out_alpha)
  );

endmodule
